FILE: hw/rtl/gbns_pkg.sv
// Shared types, codes and constants of the Go-Back-N sender.
`default_nettype none

package gbns_pkg;

   localparam int PKT_W      = 16;
   localparam int ACK_W      = 8;
   localparam int SEQ_OUT_W  = 8;
   localparam int WIN_CFG_W  = 5;
   localparam int LIM_W      = 4;
   localparam int CSR_DATA_W = 5;
   localparam int CSR_IDX_W  = 1;

   localparam int WINDOW_MAX_DEF = 16;
   localparam int SEQ_BITS_DEF   = 8;

   localparam logic [WIN_CFG_W-1:0] WINDOW_SIZE_RESET   = 5'd4;
   localparam logic [LIM_W-1:0]     TIMEOUT_LIMIT_RESET = 4'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_LIMIT = 1'b1;

   typedef enum logic [1:0] {
      CMD_START   = 2'd0,
      CMD_ACK     = 2'd1,
      CMD_TIMEOUT = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_SEND   = 3'd0,
      ACT_RESEND = 3'd1,
      ACT_DONE   = 3'd2,
      ACT_ABORT  = 3'd3,
      ACT_IGNORE = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      EM_FLAG   = 2'd0,
      EM_SEND   = 2'd1,
      EM_RESEND = 2'd2
   } emit_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EVAL   = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_SINGLE = 5'b01000,
      ST_STREAM = 5'b10000
   } state_type;

   typedef struct packed {
      logic       load_req;
      logic       start_xfer;
      logic       set_active;
      logic       clr_active;
      logic       latch_off;
      logic       apply_ack;
      logic       bump_run;
      logic       load_cursor;
      logic       emit;
      emit_type   emit_kind;
      action_type flag_act;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    active;
      logic    total_zero;
      logic    ack_in_window;
      logic    ack_done;
      logic    run_hit;
      logic    admit_have;
      logic    admit_last;
      logic    resend_have;
      logic    resend_last;
      logic    out_free;
   } sts_type;

endpackage

`default_nettype wire

FILE: hw/rtl/gbns_ctrl.sv
// Controller state machine of the Go-Back-N sender.
`default_nettype none

module gbns_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gbns_pkg::sts_type sts,
   output gbns_pkg::ctl_type ctl
);
   import gbns_pkg::*;

   state_type  state_ff, state_in;
   logic       resend_mode_ff, resend_mode_in;
   action_type flag_act_ff, flag_act_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      resend_mode_in = resend_mode_ff;
      flag_act_in    = flag_act_ff;
      ctl            = '0;
      ctl.emit_kind  = EM_FLAG;
      ctl.flag_act   = flag_act_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = ST_EVAL;
            end
         end
         ST_EVAL: begin
            priority if (sts.cmd == CMD_START) begin
               ctl.start_xfer = 1'b1;
               if (sts.total_zero) begin
                  ctl.clr_active = 1'b1;
                  flag_act_in    = ACT_DONE;
                  state_in       = ST_SINGLE;
               end else begin
                  ctl.set_active = 1'b1;
                  resend_mode_in = 1'b0;
                  state_in       = ST_STREAM;
               end
            end else if (sts.cmd == CMD_UNUSED || !sts.active) begin
               flag_act_in = ACT_IGNORE;
               state_in    = ST_SINGLE;
            end else if (sts.cmd == CMD_ACK) begin
               if (sts.ack_in_window) begin
                  ctl.latch_off = 1'b1;
                  state_in      = ST_UPDATE;
               end else begin
                  flag_act_in = ACT_IGNORE;
                  state_in    = ST_SINGLE;
               end
            end else begin
               ctl.bump_run = 1'b1;
               if (sts.run_hit) begin
                  ctl.clr_active = 1'b1;
                  flag_act_in    = ACT_ABORT;
                  state_in       = ST_SINGLE;
               end else begin
                  ctl.load_cursor = 1'b1;
                  resend_mode_in  = 1'b1;
                  state_in        = ST_STREAM;
               end
            end
         end
         ST_UPDATE: begin
            ctl.apply_ack = 1'b1;
            if (sts.ack_done) begin
               ctl.clr_active = 1'b1;
               flag_act_in    = ACT_DONE;
               state_in       = ST_SINGLE;
            end else begin
               resend_mode_in = 1'b0;
               state_in       = ST_STREAM;
            end
         end
         ST_SINGLE: begin
            if (sts.out_free) begin
               ctl.emit      = 1'b1;
               ctl.emit_kind = EM_FLAG;
               state_in      = ST_IDLE;
            end
         end
         ST_STREAM: begin
            if (resend_mode_ff) begin
               if (!sts.resend_have) begin
                  state_in = ST_IDLE;
               end else if (sts.out_free) begin
                  ctl.emit      = 1'b1;
                  ctl.emit_kind = EM_RESEND;
                  if (sts.resend_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               if (!sts.admit_have) begin
                  state_in = ST_IDLE;
               end else if (sts.out_free) begin
                  ctl.emit      = 1'b1;
                  ctl.emit_kind = EM_SEND;
                  if (sts.admit_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         resend_mode_ff <= 1'b0;
         flag_act_ff    <= ACT_IGNORE;
      end else begin
         state_ff       <= state_in;
         resend_mode_ff <= resend_mode_in;
         flag_act_ff    <= flag_act_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/gbns_dp.sv
// Datapath of the Go-Back-N sender: window state, registers and result beat register.
`default_nettype none

module gbns_dp #(
   parameter int WINDOW_MAX = gbns_pkg::WINDOW_MAX_DEF,
   parameter int SEQ_BITS   = gbns_pkg::SEQ_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [1:0]                     req_command,
   input  logic [gbns_pkg::PKT_W-1:0]     req_total_packets,
   input  logic [gbns_pkg::ACK_W-1:0]     req_ack_seq,
   input  logic                           csr_wr_en,
   input  logic [gbns_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gbns_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_action,
   output logic [gbns_pkg::PKT_W-1:0]     rsp_packet_index,
   output logic [gbns_pkg::SEQ_OUT_W-1:0] rsp_seq_no,
   output logic                           rsp_last_of_run,
   input  gbns_pkg::ctl_type              ctl,
   output gbns_pkg::sts_type              sts
);
   import gbns_pkg::*;

   localparam int WIN_W = $clog2(WINDOW_MAX + 1);
   localparam logic [PKT_W-1:0] SEQ_MASK = PKT_W'((32'd1 << SEQ_BITS) - 32'd1);

   cmd_type                 cmd_ff;
   logic [PKT_W-1:0]        req_total_ff;
   logic [ACK_W-1:0]        ack_ff;
   logic [SEQ_BITS-1:0]     off_ff;
   logic [PKT_W-1:0]        cursor_ff;
   logic [PKT_W-1:0]        base_ff, next_ff, total_ff;
   logic [LIM_W-1:0]        run_ff;
   logic                    active_ff;
   logic [WIN_CFG_W-1:0]    window_size_ff;
   logic [LIM_W-1:0]        timeout_limit_ff;
   logic                    rsp_valid_ff;
   action_type              rsp_action_ff;
   logic [PKT_W-1:0]        rsp_index_ff;
   logic [SEQ_OUT_W-1:0]    rsp_seq_ff;
   logic                    rsp_last_ff;

   logic [PKT_W-1:0]    outstanding;
   logic [PKT_W-1:0]    off_full;
   logic [SEQ_BITS-1:0] off_now;
   logic [PKT_W:0]      base_adv;
   logic [LIM_W-1:0]    run_next;
   logic [LIM_W-1:0]    lim_eff;
   logic [WIN_W-1:0]    win_eff;
   logic [PKT_W:0]      next_inc;
   logic [PKT_W:0]      cursor_inc;
   logic [PKT_W-1:0]    next_seq, cursor_seq;
   logic                out_free;

   assign outstanding = next_ff - base_ff;
   assign off_full    = PKT_W'(ack_ff) - base_ff;
   assign off_now     = off_full[SEQ_BITS-1:0];
   assign base_adv    = {1'b0, base_ff} + (PKT_W+1)'(off_ff) + (PKT_W+1)'(1);
   assign run_next    = run_ff + LIM_W'(1);
   assign lim_eff     = (timeout_limit_ff == '0) ? LIM_W'(1) : timeout_limit_ff;
   assign next_inc    = {1'b0, next_ff} + (PKT_W+1)'(1);
   assign cursor_inc  = {1'b0, cursor_ff} + (PKT_W+1)'(1);
   assign next_seq    = next_ff & SEQ_MASK;
   assign cursor_seq  = cursor_ff & SEQ_MASK;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (window_size_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (PKT_W'(window_size_ff) > PKT_W'(WINDOW_MAX)) begin
         win_eff = WIN_W'(WINDOW_MAX);
      end else begin
         win_eff = WIN_W'(window_size_ff);
      end
   end

   always_comb begin
      sts               = '0;
      sts.cmd           = cmd_ff;
      sts.active        = active_ff;
      sts.total_zero    = (req_total_ff == '0);
      sts.ack_in_window = PKT_W'(off_now) < outstanding;
      sts.ack_done      = base_adv >= {1'b0, total_ff};
      sts.run_hit       = run_next >= lim_eff;
      sts.admit_have    = (next_ff < total_ff) && (outstanding < PKT_W'(win_eff));
      sts.admit_last    = !((next_inc < {1'b0, total_ff}) &&
                            ((next_inc - {1'b0, base_ff}) < (PKT_W+1)'(win_eff)));
      sts.resend_have   = cursor_ff < next_ff;
      sts.resend_last   = cursor_inc == {1'b0, next_ff};
      sts.out_free      = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff   <= WINDOW_SIZE_RESET;
         timeout_limit_ff <= TIMEOUT_LIMIT_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_WINDOW_SIZE) begin
            window_size_ff <= csr_wdata;
         end else begin
            timeout_limit_ff <= csr_wdata[LIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         next_ff   <= '0;
         total_ff  <= '0;
         run_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         if (ctl.start_xfer) begin
            base_ff  <= '0;
            next_ff  <= '0;
            run_ff   <= '0;
            total_ff <= req_total_ff;
         end
         if (ctl.apply_ack) begin
            base_ff <= base_adv[PKT_W-1:0];
            run_ff  <= '0;
         end
         if (ctl.bump_run) begin
            run_ff <= run_next;
         end
         if (ctl.emit && ctl.emit_kind == EM_SEND) begin
            next_ff <= next_inc[PKT_W-1:0];
         end
         if (ctl.set_active) begin
            active_ff <= 1'b1;
         end else if (ctl.clr_active) begin
            active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         cmd_ff       <= cmd_type'(req_command);
         req_total_ff <= req_total_packets;
         ack_ff       <= req_ack_seq;
      end
      if (ctl.latch_off) begin
         off_ff <= off_now;
      end
      if (ctl.load_cursor) begin
         cursor_ff <= base_ff;
      end else if (ctl.emit && ctl.emit_kind == EM_RESEND) begin
         cursor_ff <= cursor_inc[PKT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         unique case (ctl.emit_kind)
            EM_SEND: begin
               rsp_action_ff <= ACT_SEND;
               rsp_index_ff  <= next_ff;
               rsp_seq_ff    <= next_seq[SEQ_OUT_W-1:0];
               rsp_last_ff   <= sts.admit_last;
            end
            EM_RESEND: begin
               rsp_action_ff <= ACT_RESEND;
               rsp_index_ff  <= cursor_ff;
               rsp_seq_ff    <= cursor_seq[SEQ_OUT_W-1:0];
               rsp_last_ff   <= sts.resend_last;
            end
            default: begin
               rsp_action_ff <= ctl.flag_act;
               rsp_index_ff  <= '0;
               rsp_seq_ff    <= '0;
               rsp_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = rsp_action_ff;
   assign rsp_packet_index = rsp_index_ff;
   assign rsp_seq_no       = rsp_seq_ff;
   assign rsp_last_of_run  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // A running transfer keeps its window ordered inside the packet count.
   a_window_order: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (base_ff <= next_ff) && (next_ff <= total_ff))
      else $error("window pointers out of order");

   // A beat is only loaded when the result register can take it.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> out_free)
      else $error("result beat overwritten");

   // Every new send beat admits exactly one packet.
   a_send_advance: assert property (@(posedge clock) disable iff (reset)
      (ctl.emit && ctl.emit_kind == EM_SEND) |=> next_ff == $past(next_inc[PKT_W-1:0]))
      else $error("next index did not advance on send");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/go_back_n_sender_top.sv
// Top level of the Go-Back-N sender: controller and datapath.
`default_nettype none

// The block takes one command beat at a time. A start, acknowledgement or
// timeout is evaluated in the EVAL state (an in-window acknowledgement
// then passes the UPDATE state) and then produces its result beats at one
// beat per cycle, while the result side does not stall, through a single
// result register. A new command beat is taken as soon as the last result
// beat of the previous one sits in the result register. Configuration
// writes take effect at once and are meant for times when no command is in
// progress.
module go_back_n_sender_top #(
   parameter int WINDOW_MAX = gbns_pkg::WINDOW_MAX_DEF,
   parameter int SEQ_BITS   = gbns_pkg::SEQ_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_command,
   input  logic [gbns_pkg::PKT_W-1:0]      req_total_packets,
   input  logic [gbns_pkg::ACK_W-1:0]      req_ack_seq,
   input  logic                            csr_wr_en,
   input  logic [gbns_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gbns_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_action,
   output logic [gbns_pkg::PKT_W-1:0]      rsp_packet_index,
   output logic [gbns_pkg::SEQ_OUT_W-1:0]  rsp_seq_no,
   output logic                            rsp_last_of_run
);
   import gbns_pkg::*;

   ctl_type ctl;
   sts_type sts;

   gbns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   gbns_dp #(
      .WINDOW_MAX (WINDOW_MAX),
      .SEQ_BITS   (SEQ_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_command),
      .req_total_packets (req_total_packets),
      .req_ack_seq       (req_ack_seq),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_action        (rsp_action),
      .rsp_packet_index  (rsp_packet_index),
      .rsp_seq_no        (rsp_seq_no),
      .rsp_last_of_run   (rsp_last_of_run),
      .ctl               (ctl),
      .sts               (sts)
   );

endmodule

`default_nettype wire

FILE: sim/go_back_n_sender_top_tb.sv
// Self-checking testbench for the Go-Back-N sender: directed table, then random phases.
`default_nettype none

module go_back_n_sender_top_tb;
   import gbns_pkg::*;

   localparam int SEQ_MASK = (1 << SEQ_BITS_DEF) - 1;

   typedef struct {
      action_type             act;
      logic [PKT_W-1:0]       idx;
      logic [SEQ_OUT_W-1:0]   seq;
      logic                   last;
   } order_beat_type;

   typedef struct {
      cmd_type          cmd;
      logic [PKT_W-1:0] total;
      logic [ACK_W-1:0] ack;
      logic             typed;
      action_type       want;
   } table_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_command = CMD_START;
   logic [PKT_W-1:0]      req_total_packets = '0;
   logic [ACK_W-1:0]      req_ack_seq = '0;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_WINDOW_SIZE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [2:0]            rsp_action;
   logic [PKT_W-1:0]      rsp_packet_index;
   logic [SEQ_OUT_W-1:0]  rsp_seq_no;
   logic                  rsp_last_of_run;

   go_back_n_sender_top uut (.*);

   always #4 clock = ~clock;

   // Shadow copy of the sender state and its registers.
   logic [WIN_CFG_W-1:0] cfg_window = WINDOW_SIZE_RESET;
   logic [LIM_W-1:0]     cfg_limit = TIMEOUT_LIMIT_RESET;
   int                   sh_base = 0;
   int                   sh_next = 0;
   int                   sh_total = 0;
   logic [LIM_W-1:0]     sh_run = '0;
   logic                 sh_active = 1'b0;

   order_beat_type pending_orders[$];
   order_beat_type new_orders[$];
   int             mismatches = 0;
   int             beats_seen = 0;
   int             req_calm = 0;
   int             rsp_calm = 0;

   table_row_type directed_rows [0:22] = '{
      '{CMD_ACK,     16'h5A5A, 8'd0,   1'b1, ACT_IGNORE},
      '{CMD_TIMEOUT, 16'hA5A5, 8'd0,   1'b1, ACT_IGNORE},
      '{CMD_UNUSED,  16'h0000, 8'd0,   1'b1, ACT_IGNORE},
      '{CMD_START,   16'd0,    8'hFF,  1'b1, ACT_DONE},
      '{CMD_START,   16'hFFFF, 8'd0,   1'b0, ACT_SEND},
      '{CMD_ACK,     16'd0,    8'hFF,  1'b1, ACT_IGNORE},
      '{CMD_ACK,     16'd0,    8'd1,   1'b0, ACT_SEND},
      '{CMD_ACK,     16'd0,    8'd3,   1'b0, ACT_SEND},
      '{CMD_TIMEOUT, 16'd0,    8'd0,   1'b0, ACT_RESEND},
      '{CMD_UNUSED,  16'hFFFF, 8'hFF,  1'b1, ACT_IGNORE},
      '{CMD_ACK,     16'd0,    8'd4,   1'b0, ACT_SEND},
      '{CMD_START,   16'd3,    8'd0,   1'b0, ACT_SEND},
      '{CMD_ACK,     16'd0,    8'd0,   1'b0, ACT_SEND},
      '{CMD_ACK,     16'd0,    8'd2,   1'b0, ACT_DONE},
      '{CMD_ACK,     16'd0,    8'd0,   1'b1, ACT_IGNORE},
      '{CMD_START,   16'd2,    8'd0,   1'b0, ACT_SEND},
      '{CMD_TIMEOUT, 16'd0,    8'd0,   1'b0, ACT_RESEND},
      '{CMD_TIMEOUT, 16'd0,    8'd0,   1'b0, ACT_RESEND},
      '{CMD_TIMEOUT, 16'd0,    8'd0,   1'b0, ACT_RESEND},
      '{CMD_TIMEOUT, 16'd0,    8'd0,   1'b0, ACT_RESEND},
      '{CMD_TIMEOUT, 16'd0,    8'd0,   1'b1, ACT_ABORT},
      '{CMD_START,   16'd1,    8'd0,   1'b0, ACT_SEND},
      '{CMD_ACK,     16'd0,    8'd0,   1'b1, ACT_DONE}
   };

   logic [CSR_DATA_W-1:0] phase_window [0:5] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd17};
   logic [CSR_DATA_W-1:0] phase_limit  [0:5] = '{5'd15, 5'd1, 5'd0, 5'h13, 5'd2, 5'h19};

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(4, 24);
      return $urandom_range(0, 14);
   endfunction

   function automatic void add_order(action_type act, int idx);
      order_beat_type b;
      b.act  = act;
      b.idx  = (act == ACT_SEND || act == ACT_RESEND) ? PKT_W'(idx) : '0;
      b.seq  = (act == ACT_SEND || act == ACT_RESEND) ? SEQ_OUT_W'(idx & SEQ_MASK) : '0;
      b.last = 1'b0;
      new_orders.push_back(b);
   endfunction

   function automatic void admit_window();
      int win;
      win = (cfg_window == 0) ? 1 : (cfg_window > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : cfg_window;
      while (sh_next < sh_total && sh_next - sh_base < win) begin
         add_order(ACT_SEND, sh_next);
         sh_next++;
      end
   endfunction

   // Applies one command to the shadow state and collects the orders it causes.
   function automatic void advance_sender(cmd_type cmd, logic [PKT_W-1:0] total,
                                          logic [ACK_W-1:0] ack);
      int off;
      int lim;
      new_orders.delete();
      if (cmd == CMD_START) begin
         sh_base  = 0;
         sh_next  = 0;
         sh_run   = '0;
         sh_total = int'(total);
         if (total == 0) begin
            sh_active = 1'b0;
            add_order(ACT_DONE, 0);
         end else begin
            sh_active = 1'b1;
            admit_window();
         end
      end else if (cmd == CMD_UNUSED || !sh_active) begin
         add_order(ACT_IGNORE, 0);
      end else if (cmd == CMD_ACK) begin
         off = (int'(ack) - sh_base) & SEQ_MASK;
         if (off >= sh_next - sh_base) begin
            add_order(ACT_IGNORE, 0);
         end else begin
            sh_base += off + 1;
            sh_run = '0;
            if (sh_base >= sh_total) begin
               sh_active = 1'b0;
               add_order(ACT_DONE, 0);
            end else begin
               admit_window();
            end
         end
      end else begin
         lim = (cfg_limit == 0) ? 1 : cfg_limit;
         sh_run = sh_run + 1'b1;
         if (sh_run >= lim) begin
            sh_active = 1'b0;
            add_order(ACT_ABORT, 0);
         end else begin
            for (int i = sh_base; i < sh_next; i++) add_order(ACT_RESEND, i);
         end
      end
      if (new_orders.size() > 0) new_orders[new_orders.size()-1].last = 1'b1;
   endfunction

   function automatic void pick_item(output cmd_type cmd, output logic [PKT_W-1:0] total,
                                     output logic [ACK_W-1:0] ack);
      int roll;
      int outstanding;
      roll = $urandom_range(0, 99);
      total = PKT_W'($urandom);
      ack = ACK_W'($urandom);
      outstanding = sh_next - sh_base;
      if (!sh_active) begin
         if (roll < 85) cmd = CMD_START;
         else if (roll < 91) cmd = CMD_ACK;
         else if (roll < 96) cmd = CMD_TIMEOUT;
         else cmd = CMD_UNUSED;
      end else if (roll < 68 && outstanding > 0) begin
         cmd = CMD_ACK;
         if ($urandom_range(0, 1) == 0) ack = ACK_W'(sh_base + outstanding - 1);
         else ack = ACK_W'(sh_base + $urandom_range(0, outstanding - 1));
      end else if (roll < 78) begin
         cmd = CMD_ACK;
      end else if (roll < 90) begin
         cmd = CMD_TIMEOUT;
      end else if (roll < 96) begin
         cmd = CMD_START;
      end else begin
         cmd = CMD_UNUSED;
      end
      if (cmd == CMD_START) begin
         roll = $urandom_range(0, 99);
         if (roll < 75) total = PKT_W'($urandom_range(1, 40));
         else if (roll < 90) total = PKT_W'($urandom_range(41, 400));
         else if (roll < 97) total = PKT_W'($urandom);
         else total = (roll == 99) ? 16'd0 : 16'hFFFF;
      end
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic send_command(cmd_type cmd, logic [PKT_W-1:0] total,
                               logic [ACK_W-1:0] ack, logic typed, action_type want);
      int gap;
      order_beat_type b;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_total_packets <= total;
      req_ack_seq       <= ack;
      do @(posedge clock); while (req_stall);
      advance_sender(cmd, total, ack);
      if (typed) begin
         b = '{want, '0, '0, 1'b1};
         pending_orders.push_back(b);
      end else begin
         foreach (new_orders[i]) pending_orders.push_back(new_orders[i]);
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      if (idx == CSR_WINDOW_SIZE) cfg_window = data;
      else cfg_limit = data[LIM_W-1:0];
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Holds the command side until every expected beat has come, then lets the block settle.
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_orders.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (24) @(posedge clock);
   endtask

   initial begin
      int hold;
      forever begin
         hold = draw_wait(rsp_calm);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      order_beat_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (pending_orders.size() == 0) begin
            report_mismatch($sformatf("beat %0d with nothing expected, action %0d",
                                      beats_seen, rsp_action));
         end else begin
            w = pending_orders.pop_front();
            if (rsp_action !== w.act)
               report_mismatch($sformatf("beat %0d action %0d, want %0d",
                                         beats_seen, rsp_action, w.act));
            if (rsp_packet_index !== w.idx)
               report_mismatch($sformatf("beat %0d packet_index %0d, want %0d",
                                         beats_seen, rsp_packet_index, w.idx));
            if (rsp_seq_no !== w.seq)
               report_mismatch($sformatf("beat %0d seq_no %0d, want %0d",
                                         beats_seen, rsp_seq_no, w.seq));
            if (rsp_last_of_run !== w.last)
               report_mismatch($sformatf("beat %0d last_of_run %0b, want %0b",
                                         beats_seen, rsp_last_of_run, w.last));
         end
      end
   end

   initial begin
      cmd_type          cmd;
      logic [PKT_W-1:0] total;
      logic [ACK_W-1:0] ack;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[r])
         send_command(directed_rows[r].cmd, directed_rows[r].total, directed_rows[r].ack,
                      directed_rows[r].typed, directed_rows[r].want);
      for (int p = 0; p < 6; p++) begin
         settle();
         write_csr(CSR_WINDOW_SIZE, phase_window[p]);
         write_csr(CSR_TIMEOUT_LIMIT, phase_limit[p]);
         for (int n = 0; n < 35; n++) begin
            pick_item(cmd, total, ack);
            send_command(cmd, total, ack, 1'b0, ACT_SEND);
         end
      end
      settle();
      if (pending_orders.size() != 0)
         report_mismatch($sformatf("%0d expected beats never came", pending_orders.size()));
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
